// ===== rtl/core/segi_pkg.sv =====
// Shared constants for the 2-D segment intersection pipeline.
package segi_pkg;

  // Fraction bits of the crossing parameter t (unsigned Q0.24)
  localparam int unsigned T_FRAC = 24;

endpackage

// ===== rtl/core/segment_intersection_2d.sv =====
// Top level: pipelined 2-D segment crossing test with a divider cell chain.
// One segment pair is taken every cycle unless the output is held; each result
// passes 8 arithmetic stages, 24 divider cells and one output register.
// The chain of cells forms t one bit per cell.
// All stages advance together; a stall at the output holds the whole
// pipeline, and the input stalls exactly when the output is held.
module segment_intersection_2d #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_ref_start_x,
  input  logic signed [COORD_BITS-1:0] in_ref_start_y,
  input  logic signed [COORD_BITS-1:0] in_ref_end_x,
  input  logic signed [COORD_BITS-1:0] in_ref_end_y,
  input  logic signed [COORD_BITS-1:0] in_test_start_x,
  input  logic signed [COORD_BITS-1:0] in_test_start_y,
  input  logic signed [COORD_BITS-1:0] in_test_end_x,
  input  logic signed [COORD_BITS-1:0] in_test_end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic signed [COORD_BITS-1:0] out_cross_x,
  output logic signed [COORD_BITS-1:0] out_cross_y
);
  import segi_pkg::*;

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned DW     = C + 1;          // coordinate difference
  localparam int unsigned PW     = 2 * DW;         // product of differences
  localparam int unsigned XW     = PW + 1;         // cross product
  localparam int unsigned LW     = PW + 1;         // |p|^2, unsigned
  localparam int unsigned D_W    = XW + 1;         // numerator / denominator
  localparam int unsigned MW     = T_FRAC + 1 + DW; // t * delta
  localparam int unsigned RW     = DW + 1;         // point minus P0
  localparam int unsigned PRW    = RW + DW;        // projection term
  localparam int unsigned SIDE_W = 6 * DW + 2 * C + LW + 2;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: differences
  logic                 v1_r;
  logic signed [DW-1:0] px1_r, py1_r, ax1_r, ay1_r, bx1_r, by1_r, qdx1_r, qdy1_r;
  logic signed [C-1:0]  q0x1_r, q0y1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r  <= DW'(in_ref_end_x)   - DW'(in_ref_start_x);
      py1_r  <= DW'(in_ref_end_y)   - DW'(in_ref_start_y);
      ax1_r  <= DW'(in_test_start_x) - DW'(in_ref_start_x);
      ay1_r  <= DW'(in_test_start_y) - DW'(in_ref_start_y);
      bx1_r  <= DW'(in_test_end_x)  - DW'(in_ref_start_x);
      by1_r  <= DW'(in_test_end_y)  - DW'(in_ref_start_y);
      qdx1_r <= DW'(in_test_end_x)  - DW'(in_test_start_x);
      qdy1_r <= DW'(in_test_end_y)  - DW'(in_test_start_y);
      q0x1_r <= in_test_start_x;
      q0y1_r <= in_test_start_y;
    end
  end

  // stage 2: products
  logic                 v2_r;
  logic signed [PW-1:0] m_pay_r, m_pyax_r, m_pby_r, m_pybx_r, s_px_r, s_py_r;
  logic signed [DW-1:0] px2_r, py2_r, ax2_r, ay2_r, qdx2_r, qdy2_r;
  logic signed [C-1:0]  q0x2_r, q0y2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m_pay_r  <= px1_r * ay1_r;
      m_pyax_r <= py1_r * ax1_r;
      m_pby_r  <= px1_r * by1_r;
      m_pybx_r <= py1_r * bx1_r;
      s_px_r   <= px1_r * px1_r;
      s_py_r   <= py1_r * py1_r;
      px2_r  <= px1_r;  py2_r  <= py1_r;
      ax2_r  <= ax1_r;  ay2_r  <= ay1_r;
      qdx2_r <= qdx1_r; qdy2_r <= qdy1_r;
      q0x2_r <= q0x1_r; q0y2_r <= q0y1_r;
    end
  end

  // stage 3: cross products and squared length
  logic                 v3_r;
  logic signed [XW-1:0] da3_r, db3_r;
  logic [LW-1:0]        len3_r;
  logic signed [DW-1:0] px3_r, py3_r, ax3_r, ay3_r, qdx3_r, qdy3_r;
  logic signed [C-1:0]  q0x3_r, q0y3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      da3_r  <= XW'(m_pay_r) - XW'(m_pyax_r);
      db3_r  <= XW'(m_pby_r) - XW'(m_pybx_r);
      len3_r <= LW'(s_px_r[PW-2:0]) + LW'(s_py_r[PW-2:0]);
      px3_r  <= px2_r;  py3_r  <= py2_r;
      ax3_r  <= ax2_r;  ay3_r  <= ay2_r;
      qdx3_r <= qdx2_r; qdy3_r <= qdy2_r;
      q0x3_r <= q0x2_r; q0y3_r <= q0y2_r;
    end
  end

  // stage 4: magnitudes, side test, saturation case
  logic signed [D_W-1:0] da_ext, db_ext;
  logic [D_W-1:0]        num_nxt, dbm_nxt;
  always_comb begin
    da_ext  = D_W'(da3_r);
    db_ext  = D_W'(db3_r);
    num_nxt = da_ext[D_W-1] ? D_W'(-da_ext) : D_W'(da_ext);
    dbm_nxt = db_ext[D_W-1] ? D_W'(-db_ext) : D_W'(db_ext);
  end

  logic              v4_r;
  logic [D_W-1:0]    num4_r, den4_r;
  logic [SIDE_W-1:0] side4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num4_r  <= num_nxt;
      den4_r  <= num_nxt + dbm_nxt;
      side4_r <= {da3_r[XW-1] ^ db3_r[XW-1], (db3_r == '0), len3_r,
                  px3_r, py3_r, ax3_r, ay3_r, qdx3_r, qdy3_r, q0x3_r, q0y3_r};
    end
  end

  // valid chain for the arithmetic stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // divider chain: one quotient bit per cell
  logic                 cv   [T_FRAC+1];
  logic [D_W-1:0]       crem [T_FRAC+1];
  logic [D_W-1:0]       cden [T_FRAC+1];
  logic [T_FRAC-1:0]    cquo [T_FRAC+1];
  logic [SIDE_W-1:0]    cside[T_FRAC+1];

  assign cv[0]    = v4_r;
  assign crem[0]  = num4_r;
  assign cden[0]  = den4_r;
  assign cquo[0]  = '0;
  assign cside[0] = side4_r;

  for (genvar g = 0; g < T_FRAC; g++) begin : g_div
    segi_div_cell #(.D_W(D_W), .SIDE_W(SIDE_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .up_valid(cv[g]),
      .up_rem  (crem[g]),
      .up_den  (cden[g]),
      .up_quo  (cquo[g]),
      .up_side (cside[g]),
      .dn_valid(cv[g+1]),
      .dn_rem  (crem[g+1]),
      .dn_den  (cden[g+1]),
      .dn_quo  (cquo[g+1]),
      .dn_side (cside[g+1])
    );
  end

  // unpack side data at the chain's end
  logic                 diff_c, sat_c;
  logic [LW-1:0]        len_c;
  logic signed [DW-1:0] px_c, py_c, ax_c, ay_c, qdx_c, qdy_c;
  logic signed [C-1:0]  q0x_c, q0y_c;
  logic [T_FRAC-1:0]    t_c;
  assign {diff_c, sat_c, len_c, px_c, py_c, ax_c, ay_c, qdx_c, qdy_c, q0x_c, q0y_c}
    = cside[T_FRAC];
  assign t_c = sat_c ? '1 : cquo[T_FRAC];

  // stage 5: t times test segment delta
  logic                 v5_r, diff5_r;
  logic signed [MW-1:0] mx5_r, my5_r;
  logic [LW-1:0]        len5_r;
  logic signed [DW-1:0] px5_r, py5_r, ax5_r, ay5_r;
  logic signed [C-1:0]  q0x5_r, q0y5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mx5_r   <= $signed({1'b0, t_c}) * qdx_c;
      my5_r   <= $signed({1'b0, t_c}) * qdy_c;
      diff5_r <= diff_c;
      len5_r  <= len_c;
      px5_r  <= px_c;  py5_r  <= py_c;
      ax5_r  <= ax_c;  ay5_r  <= ay_c;
      q0x5_r <= q0x_c; q0y5_r <= q0y_c;
    end
  end

  // stage 6: floor shift, point and offset from P0
  logic signed [DW-1:0] offx, offy;
  assign offx = mx5_r[T_FRAC+DW-1:T_FRAC];
  assign offy = my5_r[T_FRAC+DW-1:T_FRAC];

  logic                 v6_r, diff6_r;
  logic signed [RW-1:0] rx6_r, ry6_r;
  logic signed [C-1:0]  cx6_r, cy6_r;
  logic [LW-1:0]        len6_r;
  logic signed [DW-1:0] px6_r, py6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rx6_r   <= RW'(ax5_r) + RW'(offx);
      ry6_r   <= RW'(ay5_r) + RW'(offy);
      cx6_r   <= q0x5_r + offx[C-1:0];
      cy6_r   <= q0y5_r + offy[C-1:0];
      diff6_r <= diff5_r;
      len6_r  <= len5_r;
      px6_r   <= px5_r;
      py6_r   <= py5_r;
    end
  end

  // stage 7: projection terms
  logic                  v7_r, diff7_r;
  logic signed [PRW-1:0] tx7_r, ty7_r;
  logic signed [C-1:0]   cx7_r, cy7_r;
  logic [LW-1:0]         len7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tx7_r   <= rx6_r * px6_r;
      ty7_r   <= ry6_r * py6_r;
      cx7_r   <= cx6_r;
      cy7_r   <= cy6_r;
      diff7_r <= diff6_r;
      len7_r  <= len6_r;
    end
  end

  // stage 8: projection sum
  logic                    v8_r, diff8_r;
  logic signed [PRW:0]     di8_r;
  logic signed [C-1:0]     cx8_r, cy8_r;
  logic [LW-1:0]           len8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      di8_r   <= (PRW+1)'(tx7_r) + (PRW+1)'(ty7_r);
      cx8_r   <= cx7_r;
      cy8_r   <= cy7_r;
      diff8_r <= diff7_r;
      len8_r  <= len7_r;
    end
  end

  // strict bound test
  logic hit_nxt;
  assign hit_nxt = diff8_r && (di8_r > 0) && (di8_r < $signed({1'b0, len8_r}));

  // output register
  logic                out_valid_r, hit_r;
  logic signed [C-1:0] cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v5_r        <= cv[T_FRAC];
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      out_valid_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
      cx_r  <= hit_nxt ? cx8_r : '0;
      cy_r  <= hit_nxt ? cy8_r : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = hit_r;
  assign out_cross_x = cx_r;
  assign out_cross_y = cy_r;

endmodule

// ===== rtl/core/segi_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit of t per cycle while en is high.
module segi_div_cell #(
  parameter int unsigned D_W    = 52,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             up_valid,
  input  logic [D_W-1:0]                   up_rem,
  input  logic [D_W-1:0]                   up_den,
  input  logic [segi_pkg::T_FRAC-1:0]      up_quo,
  input  logic [SIDE_W-1:0]                up_side,
  output logic                             dn_valid,
  output logic [D_W-1:0]                   dn_rem,
  output logic [D_W-1:0]                   dn_den,
  output logic [segi_pkg::T_FRAC-1:0]      dn_quo,
  output logic [SIDE_W-1:0]                dn_side
);
  import segi_pkg::*;

  logic [D_W:0]         rem_sh;
  logic                 take;
  logic [D_W-1:0]       rem_nxt;
  logic [T_FRAC-1:0]    quo_nxt;
  logic                 valid_r;
  logic [D_W-1:0]       rem_r;
  logic [D_W-1:0]       den_r;
  logic [T_FRAC-1:0]    quo_r;
  logic [SIDE_W-1:0]    side_r;

  // shift remainder, trial subtract
  always_comb begin
    rem_sh  = {up_rem, 1'b0};
    take    = (rem_sh >= {1'b0, up_den});
    rem_nxt = take ? D_W'(rem_sh - {1'b0, up_den}) : rem_sh[D_W-1:0];
    quo_nxt = {up_quo[T_FRAC-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den_r  <= up_den;
      quo_r  <= quo_nxt;
      side_r <= up_side;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rem   = rem_r;
  assign dn_den   = den_r;
  assign dn_quo   = quo_r;
  assign dn_side  = side_r;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the segment_intersection_2d crossing pipeline.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 24;
  localparam int RANDOM_PAIRS = 1700;
  localparam int DRAIN_CYCLES = 40;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    coord_t p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y;
  } seg_pair_t;

  typedef struct {
    logic   hit;
    coord_t x, y;
  } crossing_t;

  // one directed request; known == 1 means the crossing is typed in
  typedef struct {
    seg_pair_t pair;
    logic      known;
    crossing_t want;
  } directed_row_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t in_ref_start_x = '0, in_ref_start_y = '0, in_ref_end_x = '0, in_ref_end_y = '0;
  coord_t in_test_start_x = '0, in_test_start_y = '0, in_test_end_x = '0, in_test_end_y = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   out_hit;
  coord_t out_cross_x, out_cross_y;

  crossing_t pending_crossings[$];
  logic      next_known = 1'b0;
  crossing_t next_typed;
  int        error_count = 0;

  segment_intersection_2d #(.COORD_BITS(CB)) dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // crossing predictor: side test, Q0.24 fraction, projection bound
  function automatic crossing_t predict_crossing(seg_pair_t s);
    longint px, py, ax, ay, bx, by, da, db, ox, oy, rx, ry, proj, len2;
    longint unsigned num, den;
    logic [127:0] quot;
    longint t;
    crossing_t c;
    c = '{hit: 1'b0, x: '0, y: '0};
    px = longint'(s.p1x) - longint'(s.p0x);
    py = longint'(s.p1y) - longint'(s.p0y);
    ax = longint'(s.q0x) - longint'(s.p0x);
    ay = longint'(s.q0y) - longint'(s.p0y);
    bx = longint'(s.q1x) - longint'(s.p0x);
    by = longint'(s.q1y) - longint'(s.p0y);
    da = px * ay - py * ax;
    db = px * by - py * bx;
    if ((da < 0) == (db < 0)) return c;
    num = (da < 0) ? -da : da;
    den = num + ((db < 0) ? -db : db);
    // exact one saturates to the largest fraction
    if (num >= den) t = (64'd1 << segi_pkg::T_FRAC) - 1;
    else begin
      quot = ({64'd0, num} << segi_pkg::T_FRAC) / {64'd0, den};
      t = longint'(quot[63:0]);
    end
    // arithmetic shift floors toward minus infinity
    ox = (t * (longint'(s.q1x) - longint'(s.q0x))) >>> segi_pkg::T_FRAC;
    oy = (t * (longint'(s.q1y) - longint'(s.q0y))) >>> segi_pkg::T_FRAC;
    rx = ax + ox;
    ry = ay + oy;
    proj = rx * px + ry * py;
    len2 = px * px + py * py;
    if (proj > 0 && proj < len2) begin
      c.hit = 1'b1;
      c.x = coord_t'(longint'(s.q0x) + ox);
      c.y = coord_t'(longint'(s.q0y) + oy);
    end
    return c;
  endfunction

  // signed value of the given bit count
  function automatic coord_t rand_coord(int bits);
    longint v;
    v = longint'($urandom) & ((64'd1 << bits) - 1);
    return coord_t'(v - (64'd1 << (bits - 1)));
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // random pair: mostly crossings built around a point on P0-P1
  function automatic seg_pair_t rand_pair();
    seg_pair_t s;
    int bits, f;
    longint mx, my, vx, vy, k;
    bits = $urandom_range(21, 4);
    if ($urandom_range(99) < 30) begin
      s = '{rand_coord(CB), rand_coord(CB), rand_coord(CB), rand_coord(CB),
            rand_coord(CB), rand_coord(CB), rand_coord(CB), rand_coord(CB)};
      return s;
    end
    s.p0x = rand_coord(bits);
    s.p0y = rand_coord(bits);
    s.p1x = rand_coord(bits);
    s.p1y = rand_coord(bits);
    f = $urandom_range(256);
    mx = longint'(s.p0x) + ((longint'(s.p1x) - longint'(s.p0x)) * f) / 256;
    my = longint'(s.p0y) + ((longint'(s.p1y) - longint'(s.p0y)) * f) / 256;
    vx = longint'(rand_coord(bits));
    vy = longint'(rand_coord(bits));
    k = $urandom_range(4);
    s.q0x = coord_t'(mx + vx);
    s.q0y = coord_t'(my + vy);
    s.q1x = coord_t'(mx - vx * k);
    s.q1y = coord_t'(my - vy * k);
    return s;
  endfunction

  task automatic send_pair(seg_pair_t s, logic known, crossing_t want, int gap);
    in_valid = 1'b0;
    repeat (gap) @(negedge clk);
    in_ref_start_x = s.p0x;  in_ref_start_y = s.p0y;
    in_ref_end_x = s.p1x;    in_ref_end_y = s.p1y;
    in_test_start_x = s.q0x; in_test_start_y = s.q0y;
    in_test_end_x = s.q1x;   in_test_end_y = s.q1y;
    next_known = known;
    next_typed = want;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // queue the expected crossing on each accepted request, check each result
  always @(posedge clk) begin
    crossing_t exp_c;
    seg_pair_t s;
    if (rst_n && in_valid && !in_stall) begin
      s = '{in_ref_start_x, in_ref_start_y, in_ref_end_x, in_ref_end_y,
            in_test_start_x, in_test_start_y, in_test_end_x, in_test_end_y};
      exp_c = next_known ? next_typed : predict_crossing(s);
      pending_crossings = {pending_crossings, exp_c};
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_crossings.size() == 0) begin
        $display("%0t: unexpected result hit=%0b x=%0d y=%0d", $time, out_hit,
                 out_cross_x, out_cross_y);
        error_count++;
      end else begin
        exp_c = pending_crossings.pop_front();
        if (out_hit !== exp_c.hit) begin
          $display("%0t: hit expected %0b got %0b", $time, exp_c.hit, out_hit);
          error_count++;
        end
        if (out_cross_x !== exp_c.x) begin
          $display("%0t: cross_x expected %0d got %0d", $time, exp_c.x, out_cross_x);
          error_count++;
        end
        if (out_cross_y !== exp_c.y) begin
          $display("%0t: cross_y expected %0d got %0d", $time, exp_c.y, out_cross_y);
          error_count++;
        end
      end
    end
  end

  // receiver back-pressure: bursts of random stalls, stretches with none
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = $urandom_range(99);
      if (n < 20) begin
        out_stall = 1'b0;
        repeat ($urandom_range(60, 20)) @(negedge clk);
      end else begin
        out_stall = 1'b1;
        repeat (gap_len() + 1) @(negedge clk);
        out_stall = 1'b0;
        repeat ($urandom_range(4, 1)) @(negedge clk);
      end
    end
  end

  initial begin
    directed_row_t rows[$];
    localparam coord_t ONE = 24'sd4096;
    localparam coord_t MAXC = 24'sh7FFFFF;
    localparam coord_t MINC = -24'sh800000;
    bit quiet;
    rows = '{
      // zero-length reference
      '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{1'b0, '0, '0}},
      '{'{ONE, ONE, ONE, ONE, 0, -ONE, 2*ONE, 3*ONE}, 1'b1, '{1'b0, '0, '0}},
      // clean crossing at the middle
      '{'{0, 0, 4*ONE, 0, 2*ONE, -ONE, 2*ONE, ONE}, 1'b1, '{1'b1, 2*ONE, 0}},
      // same side
      '{'{0, 0, 4*ONE, 0, 2*ONE, ONE, 3*ONE, 2*ONE}, 1'b1, '{1'b0, '0, '0}},
      '{'{0, 0, 4*ONE, 0, 2*ONE, -ONE, 3*ONE, -2*ONE}, 1'b1, '{1'b0, '0, '0}},
      // crossing exactly at the reference start and end
      '{'{0, 0, 4*ONE, 0, 0, -ONE, 0, ONE}, 1'b1, '{1'b0, '0, '0}},
      '{'{0, 0, 4*ONE, 0, 4*ONE, -ONE, 4*ONE, ONE}, 1'b1, '{1'b0, '0, '0}},
      // beyond the reference end
      '{'{0, 0, 4*ONE, 0, 5*ONE, -ONE, 5*ONE, ONE}, 1'b1, '{1'b0, '0, '0}},
      // fraction of one saturates, truncation leaves y one LSB short
      '{'{0, 0, 4*ONE, 0, 2*ONE, -ONE, 2*ONE, 0}, 1'b1, '{1'b1, 2*ONE, -1}},
      // test start on the line counts as positive
      '{'{0, 0, 4*ONE, 0, 2*ONE, 0, 2*ONE, -ONE}, 1'b0, '{1'b0, '0, '0}},
      // coordinate extremes
      '{'{MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC}, 1'b0, '{1'b0, '0, '0}},
      '{'{MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC}, 1'b0, '{1'b0, '0, '0}},
      '{'{MINC, 0, MAXC, 0, 0, MINC, 0, MAXC}, 1'b0, '{1'b0, '0, '0}},
      '{'{MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC}, 1'b1, '{1'b0, '0, '0}},
      '{'{MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC}, 1'b1, '{1'b0, '0, '0}},
      // tiny segments and a steep, odd-ratio crossing
      '{'{0, 0, 3, 1, 1, -2, 2, 5}, 1'b0, '{1'b0, '0, '0}},
      '{'{-7*ONE, 3*ONE, 5*ONE, -ONE, -ONE, -6*ONE, 2*ONE, 7*ONE}, 1'b0, '{1'b0, '0, '0}},
      '{'{0, 0, 0, 4*ONE, -ONE, 3, ONE, 1}, 1'b0, '{1'b0, '0, '0}}
    };

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) send_pair(rows[i].pair, rows[i].known, rows[i].want, gap_len());

    quiet = 1'b0;
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 150 == 0) quiet = ($urandom_range(2) == 0);
      send_pair(rand_pair(), 1'b0, '{1'b0, '0, '0}, quiet ? 0 : gap_len());
    end
    in_valid = 1'b0;

    wait (pending_crossings.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_crossings.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/segi_pkg.sv
rtl/core/segi_div_cell.sv
rtl/core/segment_intersection_2d.sv
sim/tb_top.sv
